@@ sv/sqct_pkg.sv @@
`default_nettype none
package sqct_pkg;

    // Default sine/cosine table depth (entries per full turn)
    localparam int DEFAULT_TABLE_DEPTH = 1024;
    // Items buffered between front and back
    localparam int QUEUE_DEPTH = 4;

    // Widths
    localparam int COORD_W  = 24;  // Q16.8 port coordinate
    localparam int OFS_W    = 33;  // rounded scaled corner offset
    localparam int PIV_W    = 25;  // world pivot pos + origin
    localparam int IDX_W    = 16;  // widest table index
    localparam int TRIG_W   = 17;  // Q1.14 sine/cosine, +/-16384 included
    localparam int TEX_W    = 17;
    localparam int RGBA_W   = 32;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TEX_U_LEFT   = 3'd0,
        CFG_TEX_V_TOP    = 3'd1,
        CFG_TEX_U_RIGHT  = 3'd2,
        CFG_TEX_V_BOTTOM = 3'd3,
        CFG_TINT_RGBA    = 3'd4
    } t_cfg_idx;

    // Classified sprite handed from front to back
    typedef struct packed {
        logic signed [OFS_W-1:0] fx;
        logic signed [OFS_W-1:0] fy;
        logic signed [OFS_W-1:0] fx2;
        logic signed [OFS_W-1:0] fy2;
        logic signed [PIV_W-1:0] wx;
        logic signed [PIV_W-1:0] wy;
        logic                    rot;
        logic [IDX_W-1:0]        idx;
    } t_item;

endpackage
`default_nettype wire

@@ sv/sqct_front.sv @@
`default_nettype none
module sqct_front #(
    parameter int ANGLE_TABLE_DEPTH = sqct_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [23:0]   i_pos_x,
    input  wire logic [23:0]   i_pos_y,
    input  wire logic [23:0]   i_width,
    input  wire logic [23:0]   i_height,
    input  wire logic [23:0]   i_origin_x,
    input  wire logic [23:0]   i_origin_y,
    input  wire logic [15:0]   i_scale_x,
    input  wire logic [15:0]   i_scale_y,
    input  wire logic [15:0]   i_angle,
    output logic               o_valid,
    input  wire logic          i_ready,
    output sqct_pkg::t_item    o_item
);
    import sqct_pkg::*;

    localparam int PROD_W = PIV_W + 16;
    localparam int IW     = $clog2(ANGLE_TABLE_DEPTH);
    localparam logic [16:0] DEPTH17 = 17'(ANGLE_TABLE_DEPTH);

    logic                     r_v;
    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [PIV_W-1:0]  r_wx, r_wy;
    logic                     r_rot;
    logic [IW-1:0]            r_idx;

    logic signed [PIV_W-1:0] ox, oy, nox, noy, dx, dy;
    logic [32:0]             idx_full;
    logic                    take;

    assign ox  = PIV_W'($signed(i_origin_x));
    assign oy  = PIV_W'($signed(i_origin_y));
    assign nox = -ox;
    assign noy = -oy;
    assign dx  = PIV_W'($signed(i_width)) - ox;
    assign dy  = PIV_W'($signed(i_height)) - oy;
    assign idx_full = {17'd0, i_angle} * {16'd0, DEPTH17};

    assign o_ready = !r_v || i_ready;
    assign take    = i_valid && o_ready;

    // Product stage: corner offsets times scale, pivot, table index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (take) begin
            r_p0  <= PROD_W'(nox * $signed(i_scale_x));
            r_p1  <= PROD_W'(noy * $signed(i_scale_y));
            r_p2  <= PROD_W'(dx  * $signed(i_scale_x));
            r_p3  <= PROD_W'(dy  * $signed(i_scale_y));
            r_wx  <= PIV_W'($signed(i_pos_x)) + ox;
            r_wy  <= PIV_W'($signed(i_pos_y)) + oy;
            r_rot <= (i_angle != 16'd0);
            r_idx <= idx_full[16 +: IW];
        end
    end

    // Round half up from Q.16 to Q.8
    function automatic logic signed [OFS_W-1:0] rnd8(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(128);
        return OFS_W'(t >>> 8);
    endfunction

    assign o_valid    = r_v;
    assign o_item.fx  = rnd8(r_p0);
    assign o_item.fy  = rnd8(r_p1);
    assign o_item.fx2 = rnd8(r_p2);
    assign o_item.fy2 = rnd8(r_p3);
    assign o_item.wx  = r_wx;
    assign o_item.wy  = r_wy;
    assign o_item.rot = r_rot;
    assign o_item.idx = IDX_W'(r_idx);

endmodule
`default_nettype wire

@@ sv/sqct_fifo.sv @@
`default_nettype none
module sqct_fifo (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  sqct_pkg::t_item i_item,
    output logic            o_not_full,
    input  wire logic       i_pop,
    output logic            o_not_empty,
    output sqct_pkg::t_item o_item
);
    import sqct_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_count;

    assign o_not_full  = (r_count != CW'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_item      = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH)) else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CW'(QUEUE_DEPTH)) || i_pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0) else $error("queue underflow");

endmodule
`default_nettype wire

@@ sv/sqct_back.sv @@
`default_nettype none
module sqct_back #(
    parameter int ANGLE_TABLE_DEPTH = sqct_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_have,
    input  sqct_pkg::t_item    i_item,
    output logic               o_pop,
    input  wire logic [16:0]   i_tex_u_left,
    input  wire logic [16:0]   i_tex_v_top,
    input  wire logic [16:0]   i_tex_u_right,
    input  wire logic [16:0]   i_tex_v_bottom,
    input  wire logic [31:0]   i_tint_rgba,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [23:0]        o_x,
    output logic [23:0]        o_y,
    output logic [16:0]        o_u,
    output logic [16:0]        o_v,
    output logic [31:0]        o_rgba,
    output logic               o_last
);
    import sqct_pkg::*;

    localparam int IW     = $clog2(ANGLE_TABLE_DEPTH);
    localparam int MUL_W  = TRIG_W + OFS_W;
    localparam int SUM_W  = MUL_W + 1;
    localparam int CRN_W  = 40;
    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
    localparam longint ONE_Q30 = 64'sd1073741824;
    // Taylor term divisors (2k)*(2k+1), k = 1..7
    localparam longint unsigned TAYLOR_DIV [8] = '{64'd1, 64'd6, 64'd20, 64'd42,
                                                   64'd72, 64'd110, 64'd156, 64'd210};

    typedef logic signed [TRIG_W-1:0] t_tab [ANGLE_TABLE_DEPTH];

    // Q1.14 sine of phase p/(4*depth) turns, Q30 Taylor series on a quarter wave
    function automatic logic signed [TRIG_W-1:0] wave(input longint unsigned p);
        longint unsigned quad, rem, x, x2, term;
        longint          sum, s;
        quad = p / ANGLE_TABLE_DEPTH;
        rem  = p % ANGLE_TABLE_DEPTH;
        x    = (rem * Q30_HALF_PI) / ANGLE_TABLE_DEPTH;
        if (quad[0]) x = Q30_HALF_PI - x;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if (k % 2 == 1) sum = sum - longint'(term);
            else            sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > ONE_Q30) sum = ONE_Q30;
        s = (sum + 64'sd32768) >>> 16;
        return quad[1] ? TRIG_W'(-s) : TRIG_W'(s);
    endfunction

    function automatic t_tab build_tab(input logic want_cos);
        t_tab            tab;
        longint unsigned p;
        for (int i = 0; i < ANGLE_TABLE_DEPTH; i++) begin
            p = 4 * longint'(i) + (want_cos ? longint'(ANGLE_TABLE_DEPTH) : 0);
            if (p >= 4 * longint'(ANGLE_TABLE_DEPTH)) p = p - 4 * longint'(ANGLE_TABLE_DEPTH);
            tab[i] = wave(p);
        end
        return tab;
    endfunction

    localparam t_tab SIN_ROM = build_tab(1'b0);
    localparam t_tab COS_ROM = build_tab(1'b1);

    logic adv;

    // Corner sequencer
    logic                     r_have;
    logic [1:0]               r_k;
    t_item                    r_item;
    logic signed [TRIG_W-1:0] r_c, r_s;

    // Multiply stage
    logic                     r_m_v, r_m_rot;
    logic [1:0]               r_m_k;
    logic signed [OFS_W-1:0]  r_m_cx, r_m_cy;
    logic signed [PIV_W-1:0]  r_m_wx, r_m_wy;
    logic signed [MUL_W-1:0]  r_m_ccx, r_m_ssy, r_m_scx, r_m_ccy;

    // Rotate stage
    logic                     r_r_v;
    logic [1:0]               r_r_k;
    logic signed [CRN_W-1:0]  r_r_x, r_r_y;
    logic signed [PIV_W-1:0]  r_r_wx, r_r_wy;
    logic signed [CRN_W-1:0]  r_cx [3];
    logic signed [CRN_W-1:0]  r_cy [3];

    // Output register
    logic                     r_o_v, r_o_last;
    logic [23:0]              r_o_x, r_o_y;
    logic [16:0]              r_o_u, r_o_v_tex;

    logic signed [OFS_W-1:0]  sel_x, sel_y;
    logic signed [SUM_W-1:0]  sum_x, sum_y;
    logic signed [CRN_W-1:0]  rot_x, rot_y, crn_x, crn_y;
    logic signed [CRN_W:0]    wld_x, wld_y;

    assign adv   = !r_o_v || i_ready;
    assign o_pop = adv && (!r_have || r_k == 2'd3) && i_have;

    always_comb begin
        unique case (r_k)
            2'd0:    begin sel_x = r_item.fx;  sel_y = r_item.fy;  end
            2'd1:    begin sel_x = r_item.fx2; sel_y = r_item.fy;  end
            2'd2:    begin sel_x = r_item.fx2; sel_y = r_item.fy2; end
            default: begin sel_x = r_item.fx;  sel_y = r_item.fy2; end
        endcase
    end

    // Sequencer and table read: one corner per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_k    <= 2'd0;
        end else if (adv) begin
            if (r_have) r_k <= r_k + 2'd1;
            if (!r_have || r_k == 2'd3) r_have <= i_have;
            if (o_pop) r_k <= 2'd0;
        end
        if (o_pop) begin
            r_item <= i_item;
            r_c    <= COS_ROM[i_item.idx[IW-1:0]];
            r_s    <= SIN_ROM[i_item.idx[IW-1:0]];
        end
    end

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (adv) begin
            r_m_v <= r_have;
        end
        if (adv && r_have) begin
            r_m_k   <= r_k;
            r_m_rot <= r_item.rot;
            r_m_cx  <= sel_x;
            r_m_cy  <= sel_y;
            r_m_wx  <= r_item.wx;
            r_m_wy  <= r_item.wy;
            r_m_ccx <= MUL_W'(r_c * sel_x);
            r_m_ssy <= MUL_W'(r_s * sel_y);
            r_m_scx <= MUL_W'(r_s * sel_x);
            r_m_ccy <= MUL_W'(r_c * sel_y);
        end
    end

    // Rotation with rounding from Q.22 to Q.8; fourth corner derived
    always_comb begin
        sum_x = SUM_W'(r_m_ccx) - SUM_W'(r_m_ssy) + SUM_W'(8192);
        sum_y = SUM_W'(r_m_scx) + SUM_W'(r_m_ccy) + SUM_W'(8192);
        rot_x = CRN_W'(sum_x >>> 14);
        rot_y = CRN_W'(sum_y >>> 14);
        if (r_m_k == 2'd3) begin
            crn_x = r_cx[0] + (r_cx[2] - r_cx[1]);
            crn_y = r_cy[2] - (r_cy[1] - r_cy[0]);
        end else if (r_m_rot) begin
            crn_x = rot_x;
            crn_y = rot_y;
        end else begin
            crn_x = CRN_W'(r_m_cx);
            crn_y = CRN_W'(r_m_cy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_v <= 1'b0;
        end else if (adv) begin
            r_r_v <= r_m_v;
        end
        if (adv && r_m_v) begin
            r_r_k  <= r_m_k;
            r_r_x  <= crn_x;
            r_r_y  <= crn_y;
            r_r_wx <= r_m_wx;
            r_r_wy <= r_m_wy;
            if (r_m_k != 2'd3) begin
                r_cx[r_m_k] <= crn_x;
                r_cy[r_m_k] <= crn_y;
            end
        end
    end

    // World offset and saturation
    function automatic logic [23:0] sat24(input logic signed [CRN_W:0] v);
        if (v > (CRN_W+1)'(8388607))  return 24'h7FFFFF;
        if (v < -(CRN_W+1)'(8388608)) return 24'h800000;
        return v[23:0];
    endfunction

    assign wld_x = (CRN_W+1)'(r_r_x) + (CRN_W+1)'(r_r_wx);
    assign wld_y = (CRN_W+1)'(r_r_y) + (CRN_W+1)'(r_r_wy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (adv) begin
            r_o_v <= r_r_v;
        end
        if (adv && r_r_v) begin
            r_o_x     <= sat24(wld_x);
            r_o_y     <= sat24(wld_y);
            r_o_u     <= (r_r_k == 2'd1 || r_r_k == 2'd2) ? i_tex_u_right : i_tex_u_left;
            r_o_v_tex <= (r_r_k[1]) ? i_tex_v_bottom : i_tex_v_top;
            r_o_last  <= (r_r_k == 2'd3);
        end
    end

    assign o_valid = r_o_v;
    assign o_x     = r_o_x;
    assign o_y     = r_o_y;
    assign o_u     = r_o_u;
    assign o_v     = r_o_v_tex;
    assign o_rgba  = i_tint_rgba;
    assign o_last  = r_o_last;

    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_have && r_k == 2'd0) else $error("pop did not start corner zero");
    a_idle_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> r_k == 2'd0) else $error("corner count left over");
    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_r_v && r_r_k == 2'd3 |=> r_o_v && r_o_last)
        else $error("fourth corner not marked last");

endmodule
`default_nettype wire

@@ sv/sprite_quad_corner_transform.sv @@
// Channel  | Dir | Beat content (low bit first)
// s_axis   | in  | tdata: pos_x, pos_y, width, height, origin_x, origin_y, scale_x, scale_y, angle
// m_axis   | out | tdata: vert_x, vert_y, vert_u, vert_v, vert_rgba; tlast: last_corner
// cfg      | in  | i_cfg_we / i_cfg_idx / i_cfg_data, one register per cycle
//
// Four output beats per sprite, one per cycle unless m_axis_tready stalls: the
// back end's single multiply lane handles one corner per cycle. Each input beat
// reaches its first vertex via front, queue, sequencer, multiply, rotate, output.
// Reset is synchronous and active low; the sine/cosine tables are constants.
// The front and back stall independently through a 4-entry queue.
`default_nettype none
module sprite_quad_corner_transform #(
    parameter int ANGLE_TABLE_DEPTH = sqct_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pos_x[23:0] pos_y[47:24] width[71:48] height[95:72] origin_x[119:96]
    // origin_y[143:120] scale_x[159:144] scale_y[175:160] angle[191:176]
    input  wire logic [191:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // vert_x[23:0] vert_y[47:24] vert_u[64:48] vert_v[81:65] vert_rgba[113:82], zero pad
    output logic [119:0]      m_axis_tdata,
    output logic              m_axis_tlast,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data
);
    import sqct_pkg::*;

    logic [16:0] r_tex_u_left, r_tex_v_top, r_tex_u_right, r_tex_v_bottom;
    logic [31:0] r_tint_rgba;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_u_left   <= 17'd0;
            r_tex_v_top    <= 17'd0;
            r_tex_u_right  <= 17'd65536;
            r_tex_v_bottom <= 17'd65536;
            r_tint_rgba    <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TEX_U_LEFT:   r_tex_u_left   <= i_cfg_data[16:0];
                CFG_TEX_V_TOP:    r_tex_v_top    <= i_cfg_data[16:0];
                CFG_TEX_U_RIGHT:  r_tex_u_right  <= i_cfg_data[16:0];
                CFG_TEX_V_BOTTOM: r_tex_v_bottom <= i_cfg_data[16:0];
                CFG_TINT_RGBA:    r_tint_rgba    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_item       f_item, q_item;
    logic        f_valid, q_not_full, q_not_empty, q_pop;
    logic [23:0] v_x, v_y;
    logic [16:0] v_u, v_v;
    logic [31:0] v_rgba;

    sqct_front #(.ANGLE_TABLE_DEPTH(ANGLE_TABLE_DEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_pos_x    (s_axis_tdata[23:0]),
        .i_pos_y    (s_axis_tdata[47:24]),
        .i_width    (s_axis_tdata[71:48]),
        .i_height   (s_axis_tdata[95:72]),
        .i_origin_x (s_axis_tdata[119:96]),
        .i_origin_y (s_axis_tdata[143:120]),
        .i_scale_x  (s_axis_tdata[159:144]),
        .i_scale_y  (s_axis_tdata[175:160]),
        .i_angle    (s_axis_tdata[191:176]),
        .o_valid    (f_valid),
        .i_ready    (q_not_full),
        .o_item     (f_item)
    );

    sqct_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_valid && q_not_full),
        .i_item      (f_item),
        .o_not_full  (q_not_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_item      (q_item)
    );

    sqct_back #(.ANGLE_TABLE_DEPTH(ANGLE_TABLE_DEPTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_have         (q_not_empty),
        .i_item         (q_item),
        .o_pop          (q_pop),
        .i_tex_u_left   (r_tex_u_left),
        .i_tex_v_top    (r_tex_v_top),
        .i_tex_u_right  (r_tex_u_right),
        .i_tex_v_bottom (r_tex_v_bottom),
        .i_tint_rgba    (r_tint_rgba),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_x            (v_x),
        .o_y            (v_y),
        .o_u            (v_u),
        .o_v            (v_v),
        .o_rgba         (v_rgba),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, v_rgba, v_v, v_u, v_y, v_x};

endmodule
`default_nettype wire

@@ dv/tb_sprite_quad_corner_transform.sv @@
module tb_sprite_quad_corner_transform;
    import sqct_pkg::*;

    localparam int DEPTH = 1024;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic [16:0]        u;
        logic [16:0]        v;
        logic [31:0]        rgba;
        logic               last;
    } vertex_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // pos_x, pos_y, width, height, origin_x, origin_y, scale_x, scale_y, angle
    logic [191:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // vert_x, vert_y, vert_u, vert_v, vert_rgba, zero pad
    logic [119:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [31:0]  i_cfg_data = '0;

    sprite_quad_corner_transform dut (.*);

    always #6 i_clk = ~i_clk;

    // Shadow registers and trig tables
    logic [16:0] u_left, v_top, u_right, v_bottom;
    logic [31:0] tint;
    longint sin_tab[DEPTH];
    longint cos_tab[DEPTH];

    vertex_t pending_vertices[$];
    int      error_count = 0;
    int      sprites_sent = 0;
    int      vertices_seen = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    longint  cycle_count = 0;

    function automatic longint round_div_pow2(longint v, int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    // Quarter-wave Taylor sine, Q30 in and out
    function automatic longint taylor_sin_q30(longint unsigned x);
        longint unsigned x2, term;
        longint sum;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k & 1) sum -= term;
            else sum += term;
        end
        if (sum < 0) sum = 0;
        if (sum > 64'd1073741824) sum = 64'd1073741824;
        return sum;
    endfunction

    function automatic longint wave_q14(longint unsigned p);
        longint unsigned quad, rem, x;
        longint s;
        quad = p / DEPTH;
        rem = p % DEPTH;
        x = (rem * 64'd1686629713) / DEPTH;
        if (quad[0]) x = 64'd1686629713 - x;
        s = (taylor_sin_q30(x) + (64'd1 << 15)) >>> 16;
        return quad[1] ? -s : s;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // Expected four corners of one sprite
    task automatic predict_quad(input logic [191:0] d);
        longint px, py, w, h, ox, oy, sx, sy, c, s, rx, ry;
        longint cx[4], cy[4];
        logic [16:0] cu[4], cv[4];
        longint unsigned ang, idx;
        vertex_t vtx;
        px = longint'($signed(d[23:0]));    py = longint'($signed(d[47:24]));
        w  = longint'($signed(d[71:48]));   h  = longint'($signed(d[95:72]));
        ox = longint'($signed(d[119:96]));  oy = longint'($signed(d[143:120]));
        sx = longint'($signed(d[159:144])); sy = longint'($signed(d[175:160]));
        ang = 64'(d[191:176]);
        cx[0] = round_div_pow2(-ox * sx, 8);
        cy[0] = round_div_pow2(-oy * sy, 8);
        cx[1] = round_div_pow2((w - ox) * sx, 8);
        cy[2] = round_div_pow2((h - oy) * sy, 8);
        cy[1] = cy[0];  cx[2] = cx[1];
        cx[3] = cx[0];  cy[3] = cy[2];
        if (ang != 0) begin
            idx = (ang * DEPTH) >> 16;
            c = cos_tab[idx];
            s = sin_tab[idx];
            for (int k = 0; k < 3; k++) begin
                rx = round_div_pow2(c * cx[k] - s * cy[k], 14);
                ry = round_div_pow2(s * cx[k] + c * cy[k], 14);
                cx[k] = rx;
                cy[k] = ry;
            end
            cx[3] = cx[0] + (cx[2] - cx[1]);
            cy[3] = cy[2] - (cy[1] - cy[0]);
        end
        cu[0] = u_left;  cv[0] = v_top;
        cu[1] = u_right; cv[1] = v_top;
        cu[2] = u_right; cv[2] = v_bottom;
        cu[3] = u_left;  cv[3] = v_bottom;
        for (int k = 0; k < 4; k++) begin
            vtx.x = 24'(clamp_coord(cx[k] + px + ox));
            vtx.y = 24'(clamp_coord(cy[k] + py + oy));
            vtx.u = cu[k];
            vtx.v = cv[k];
            vtx.rgba = tint;
            vtx.last = (k == 3);
            pending_vertices.push_back(vtx);
        end
    endtask

    // Valid stays up after the beat so the next call can follow with no gap
    task automatic send_sprite(input logic [23:0] px, py, w, h, ox, oy,
                               input logic [15:0] sx, sy, ang);
        logic [191:0] d;
        d = {ang, sy, sx, oy, ox, h, w, py, px};
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata <= d;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_quad(d);
        sprites_sent++;
        @(negedge i_clk);
    endtask

    // Drops valid, waits for all vertices, then lets the pipeline drain
    task automatic drain_quads();
        s_axis_tvalid <= 1'b0;
        while (pending_vertices.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TEX_U_LEFT:   u_left = val[16:0];
            CFG_TEX_V_TOP:    v_top = val[16:0];
            CFG_TEX_U_RIGHT:  u_right = val[16:0];
            CFG_TEX_V_BOTTOM: v_bottom = val[16:0];
            default:          tint = val;
        endcase
    endtask

    task automatic set_texture(input logic [16:0] ul, vt, ur, vb, input logic [31:0] rgba);
        drain_quads();
        write_register(CFG_TEX_U_LEFT, 32'(ul));
        write_register(CFG_TEX_V_TOP, 32'(vt));
        write_register(CFG_TEX_U_RIGHT, 32'(ur));
        write_register(CFG_TEX_V_BOTTOM, 32'(vb));
        write_register(CFG_TINT_RGBA, rgba);
    endtask

    task automatic send_random_sprite(input int mode);
        logic [23:0] f[6];
        logic [15:0] sx, sy, ang;
        for (int i = 0; i < 6; i++) begin
            f[i] = 24'($urandom);
            // mostly modest coordinates so saturation stays the exception
            if (mode != 0) f[i] = 24'($signed(f[i][15:0]));
        end
        sx = 16'($urandom);
        sy = 16'($urandom);
        ang = 16'($urandom);
        if (mode == 1) begin
            sx = 16'($signed(sx[10:0]));
            sy = 16'($signed(sy[10:0]));
        end
        if ($urandom_range(9) == 0) ang = 0;
        else if ($urandom_range(9) == 0) ang = 16'($urandom_range(63)); // index zero
        send_sprite(f[0], f[1], f[2], f[3], f[4], f[5], sx, sy, ang);
    endtask

    // Directed: plain draw, extremes, rotations, negative sizes
    task automatic test_directed();
        send_sprite(24'h000100, 24'h000200, 24'h002000, 24'h001000, 0, 0,
                    16'h0100, 16'h0100, 16'd0);
        send_sprite(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                    24'h7FFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_sprite(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
                    24'h800000, 16'h8000, 16'h8000, 16'd0);
        send_sprite(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                    24'h800000, 16'h8000, 16'h7FFF, 16'h8000);
        send_sprite(0, 0, 24'h001000, 24'h001000, 24'h000800, 24'h000800,
                    16'h0100, 16'h0100, 16'd1);   // index zero, still rotated
        send_sprite(0, 0, 24'h001000, 24'h001000, 24'h000800, 24'h000800,
                    16'h0100, 16'h0100, 16'd63);
        for (int q = 1; q < 8; q++)
            send_sprite(24'h001000, 24'hFFF000, 24'h000800, 24'h000400, 24'h000100,
                        24'h000200, 16'h0180, 16'h0080, 16'(q * 8192));
        send_sprite(0, 0, 24'hFFF000, 24'hFFE000, 0, 0, 16'hFF00, 16'h0100, 16'd0);
        send_sprite(0, 0, 24'hFFF000, 24'hFFE000, 24'hFFFF00, 24'h000100,
                    16'hFF00, 16'hFE80, 16'd12345);
        send_sprite(0, 0, 0, 0, 0, 0, 0, 0, 16'd0);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) send_random_sprite($urandom_range(2));
    endtask

    // Score each vertex beat
    always @(posedge i_clk) begin
        vertex_t want;
        if (i_rst_n) cycle_count <= cycle_count + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            vertices_seen++;
            if (pending_vertices.size() == 0) begin
                $error("vertex beat with none expected");
                error_count++;
            end else begin
                want = pending_vertices.pop_front();
                if (m_axis_tdata[23:0] !== want.x) begin
                    $error("vert_x expected %0d got %0d", want.x,
                           $signed(m_axis_tdata[23:0]));
                    error_count++;
                end
                if (m_axis_tdata[47:24] !== want.y) begin
                    $error("vert_y expected %0d got %0d", want.y,
                           $signed(m_axis_tdata[47:24]));
                    error_count++;
                end
                if (m_axis_tdata[64:48] !== want.u) begin
                    $error("vert_u expected %0d got %0d", want.u, m_axis_tdata[64:48]);
                    error_count++;
                end
                if (m_axis_tdata[81:65] !== want.v) begin
                    $error("vert_v expected %0d got %0d", want.v, m_axis_tdata[81:65]);
                    error_count++;
                end
                if (m_axis_tdata[113:82] !== want.rgba) begin
                    $error("vert_rgba expected %h got %h", want.rgba, m_axis_tdata[113:82]);
                    error_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_corner expected %b got %b", want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            sin_tab[i] = wave_q14(4 * i);
            cos_tab[i] = wave_q14((4 * i + DEPTH) % (4 * DEPTH));
        end
        u_left = 0; v_top = 0; u_right = 17'd65536; v_bottom = 17'd65536;
        tint = 32'hFFFFFFFF;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        set_texture(17'd65536, 17'd65536, 0, 0, 32'h00000000);
        test_directed();
        set_texture(17'h1FFFF, 17'd100, 17'd70000, 17'h12345, 32'h80FF017F);
        test_random(35);
        // hold off until the quad stream is empty, then resume
        drain_quads();
        send_idle_pct = 51;
        test_random(25);
        send_idle_pct = 0;
        recv_stall_pct = 51;
        set_texture(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom), $urandom);
        test_random(25);
        send_idle_pct = 18;
        recv_stall_pct = 18;
        test_random(25);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(18);
        drain_quads();

        $display("covered %0d sprites, %0d vertices, four texture settings",
                 sprites_sent, vertices_seen);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
sv/sqct_pkg.sv
sv/sqct_front.sv
sv/sqct_fifo.sv
sv/sqct_back.sv
sv/sprite_quad_corner_transform.sv
dv/tb_sprite_quad_corner_transform.sv
